// ===== rtl/average_true_range_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Average true range unit: assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_TRUE_RANGE_UNIT_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_UNIT_DEFINES_SVH

// Overlapping implication, checked while reset is released.
`define ATR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Implication that checks the consequent in the next cycle.
`define ATR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// Average true range package
// Widths, constants and shared types of the average true range unit.
// ----------------------------------------------------------------------------
`default_nettype none

package atr_pkg;

  localparam int unsigned PRICE_BITS    = 24;
  localparam int unsigned SUM_BITS      = 30;
  localparam int unsigned WIN_BITS      = 7;
  localparam int unsigned MAX_WINDOW    = 64;
  localparam int unsigned PTR_BITS      = $clog2(MAX_WINDOW);
  localparam int unsigned DIV_STEPS     = SUM_BITS;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(14);

  // Status returned by the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/atr_bar_if.sv =====
// ----------------------------------------------------------------------------
// Price bar channel
// Valid/ready channel that carries one price bar per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface atr_bar_if;
  logic                           valid;
  logic                           ready;
  logic [atr_pkg::PRICE_BITS-1:0] bar_high;
  logic [atr_pkg::PRICE_BITS-1:0] bar_low;
  logic [atr_pkg::PRICE_BITS-1:0] bar_close;
  logic                           series_start;

  modport source (output valid, bar_high, bar_low, bar_close, series_start, input ready);
  modport sink   (input valid, bar_high, bar_low, bar_close, series_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/atr_result_if.sv =====
// ----------------------------------------------------------------------------
// Average true range result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface atr_result_if;
  logic                           valid;
  logic                           ready;
  logic [atr_pkg::PRICE_BITS-1:0] average_range;
  logic [atr_pkg::SUM_BITS-1:0]   range_sum;
  logic [atr_pkg::PRICE_BITS-1:0] latest_range;

  modport source (output valid, average_range, range_sum, latest_range, input ready);
  modport sink   (input valid, average_range, range_sum, latest_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/atr_div.sv =====
// ----------------------------------------------------------------------------
// Average true range serial divider
// Restoring divider, one quotient bit per cycle, window sum by window length.
// ----------------------------------------------------------------------------
`default_nettype none

module atr_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [atr_pkg::SUM_BITS-1:0]   dividend_i,
  input  wire logic [atr_pkg::WIN_BITS-1:0]   divisor_i,
  output atr_pkg::div_stat_t                  stat_o,
  output logic      [atr_pkg::SUM_BITS-1:0]   quotient_o
);

  logic                              busy_q, done_q;
  logic [atr_pkg::DIV_CNT_BITS-1:0]  cnt_q;
  logic [atr_pkg::SUM_BITS-1:0]      dvd_q;
  logic [atr_pkg::WIN_BITS-1:0]      rem_q, dsr_q;
  logic [atr_pkg::WIN_BITS:0]        trial;
  logic                              qbit;

  // Partial remainder stays below the divisor, so the trial fits one more bit.
  assign trial = {rem_q, dvd_q[atr_pkg::SUM_BITS-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + atr_pkg::DIV_CNT_BITS'(1);
        if (cnt_q == atr_pkg::DIV_CNT_BITS'(atr_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out at the top and takes quotient bits in
  // at the bottom; after the last step it holds the quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[atr_pkg::SUM_BITS-2:0], qbit};
      if (qbit) begin
        rem_q <= atr_pkg::WIN_BITS'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[atr_pkg::WIN_BITS-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

`default_nettype wire

// ===== rtl/average_true_range_unit.sv =====
// A bar that continues a series and fills the window gives its result word
// after the true range, sum and divide steps; the unit is ready for the next bar in that same cycle.
// The unit takes no new bar before its sequence, with the 30-step serial divide, ends.
// Bars that open a series or only fill the window give no result word and skip the divide.
// Reset (asynchronous, active low) clears the window, the prior close and the
// output; the window length returns to 14. The range ring is not cleared.
// ----------------------------------------------------------------------------
// Average true range unit
// Simple moving average of the true range over a configurable window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "average_true_range_unit_defines.svh"

module average_true_range_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  atr_bar_if.sink                           bar_in,
  atr_result_if.source                      res_out,
  input  wire logic                         cfg_we_i,
  input  wire logic [atr_pkg::WIN_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned PB = atr_pkg::PRICE_BITS;
  localparam int unsigned SB = atr_pkg::SUM_BITS;
  localparam int unsigned WB = atr_pkg::WIN_BITS;
  localparam int unsigned PT = atr_pkg::PTR_BITS;

  // Sequencer: three steps through the shared difference unit build the true
  // range, then ring read, sum update, ring write and, once the window is full, the serial divide.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_HL   = 10'b00_0000_0010,
    ST_HC   = 10'b00_0000_0100,
    ST_LC   = 10'b00_0000_1000,
    ST_RD   = 10'b00_0001_0000,
    ST_SUB  = 10'b00_0010_0000,
    ST_ADD  = 10'b00_0100_0000,
    ST_DGO  = 10'b00_1000_0000,
    ST_DIV  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Window state.
  logic [WB-1:0] win_q;
  logic [WB-1:0] cnt_q;
  logic [PT-1:0] ptr_q;
  logic [SB-1:0] sum_q;
  logic [PB-1:0] prior_q;
  logic          have_prior_q;

  // Working registers of the bar in progress.
  logic [PB-1:0] hi_q, lo_q, cl_q, tr_q, old_q;
  logic [PT-1:0] slot_q;

  // Range ring.
  logic [PB-1:0] ring_q [atr_pkg::MAX_WINDOW];

  // Output register.
  logic          out_valid_q;
  logic [PB-1:0] out_avg_q, out_tr_q;
  logic [SB-1:0] out_sum_q;

  logic          accept, opens_series, out_free, window_full;
  logic [WB-1:0] win_eff;
  logic [WB-1:0] slot_next;
  logic [PT-1:0] slot_d;
  logic [PB-1:0] alu_a, alu_b, alu_diff, alu_res;
  logic [SB-1:0] sum_res;

  logic                  div_start;
  atr_pkg::div_stat_t    div_stat;
  logic [SB-1:0]         div_quot;

  assign accept       = bar_in.valid && bar_in.ready;
  assign opens_series = bar_in.series_start || !have_prior_q;
  assign out_free     = !out_valid_q || res_out.ready;
  assign window_full  = (cnt_q >= win_q);
  assign div_start    = (state_q == ST_DGO);

  assign bar_in.ready = (state_q == ST_IDLE);

  // A length of zero behaves as one; anything above the ring depth is clamped.
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      win_eff = WB'(1);
    end else if (cfg_wdata_i > WB'(atr_pkg::MAX_WINDOW)) begin
      win_eff = WB'(atr_pkg::MAX_WINDOW);
    end else begin
      win_eff = cfg_wdata_i;
    end
  end

  // Shared absolute difference unit. For the high minus low term an inverted
  // bar counts as zero.
  always_comb begin
    unique case (state_q)
      ST_HC:   begin alu_a = hi_q; alu_b = prior_q; end
      ST_LC:   begin alu_a = lo_q; alu_b = prior_q; end
      default: begin alu_a = hi_q; alu_b = lo_q;    end
    endcase
    alu_diff = (alu_a >= alu_b) ? (alu_a - alu_b) : (alu_b - alu_a);
    priority if ((state_q == ST_HL) && (alu_a < alu_b)) begin
      alu_res = '0;
    end else begin
      alu_res = alu_diff;
    end
  end

  // Shared sum adder: drops the oldest range once the window is full, then adds the newest.
  assign sum_res = (state_q == ST_SUB) ? (sum_q - SB'(old_q)) : (sum_q + SB'(tr_q));

  // A pointer left beyond a shortened window wraps to the start.
  assign slot_d    = ({1'b0, ptr_q} >= win_q) ? '0 : ptr_q;
  assign slot_next = {1'b0, slot_q} + WB'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && !opens_series) state_d = ST_HL;
      ST_HL:   state_d = ST_HC;
      ST_HC:   state_d = ST_LC;
      ST_LC:   state_d = ST_RD;
      ST_RD:   state_d = ST_SUB;
      ST_SUB:  state_d = ST_ADD;
      ST_ADD:  state_d = window_full ? ST_DGO : ST_IDLE;
      ST_DGO:  state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_q        <= atr_pkg::WINDOW_RESET;
      cnt_q        <= '0;
      ptr_q        <= '0;
      sum_q        <= '0;
      prior_q      <= '0;
      have_prior_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // The output word is raised when the sequencer hands it over and is
      // dropped once the sink has taken it.
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        // A new length restarts the window; the prior close is kept.
        win_q <= win_eff;
        cnt_q <= '0;
        ptr_q <= '0;
        sum_q <= '0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (accept && opens_series) begin
              cnt_q        <= '0;
              ptr_q        <= '0;
              sum_q        <= '0;
              prior_q      <= bar_in.bar_close;
              have_prior_q <= 1'b1;
            end
          end
          ST_LC:   prior_q <= cl_q;
          ST_SUB: begin
            if (window_full) begin
              sum_q <= sum_res;
            end else begin
              cnt_q <= cnt_q + WB'(1);
            end
          end
          ST_ADD: begin
            sum_q <= sum_res;
            ptr_q <= (slot_next >= win_q) ? '0 : slot_next[PT-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hi_q <= bar_in.bar_high;
      lo_q <= bar_in.bar_low;
      cl_q <= bar_in.bar_close;
    end
    unique case (state_q)
      ST_HL:   tr_q <= alu_res;
      ST_HC:   if (alu_res > tr_q) tr_q <= alu_res;
      ST_LC: begin
        if (alu_res > tr_q) tr_q <= alu_res;
        slot_q <= slot_d;
      end
      default: ;
    endcase
    if ((state_q == ST_OUT) && out_free) begin
      out_avg_q <= div_quot[PB-1:0];
      out_sum_q <= sum_q;
      out_tr_q  <= tr_q;
    end
  end

  // Ring memory: one registered read of the slot's oldest range, then the
  // newest range is written back to the same slot.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      old_q <= ring_q[slot_q];
    end
    if (state_q == ST_ADD) begin
      ring_q[slot_q] <= tr_q;
    end
  end

  atr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (win_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  assign res_out.valid         = out_valid_q;
  assign res_out.average_range = out_avg_q;
  assign res_out.range_sum     = out_sum_q;
  assign res_out.latest_range  = out_tr_q;

  // The number of held ranges never passes the window length.
  `ATR_ASSERT_IMP(a_cnt_in_window, clk_i, rst_ni, 1'b1, cnt_q <= win_q,
                  "filled count exceeds window length")
  // The ring pointer always addresses a slot inside the window.
  `ATR_ASSERT_IMP(a_ptr_in_window, clk_i, rst_ni, 1'b1, {1'b0, ptr_q} < win_q,
                  "ring pointer outside window")
  // A divide is never restarted while one is in progress.
  `ATR_ASSERT_IMP(a_div_start_free, clk_i, rst_ni, div_start, !div_stat.busy,
                  "divider started while busy")
  // A finished divide always leads to a result being offered.
  `ATR_ASSERT_NXT(a_div_to_out, clk_i, rst_ni,
                  (state_q == ST_DIV) && div_stat.done, state_q == ST_OUT,
                  "divider result not taken to output")

endmodule

`default_nettype wire
